FILE: hdl/lbbc_pkg.sv
`default_nettype none
package lbbc_pkg;

  localparam int unsigned EntriesDef   = 16;
  localparam int unsigned BlockBitsDef = 25;
  localparam int unsigned MaxResults   = 16;

  // operation codes
  localparam logic [2:0] OpLookup     = 3'd0;
  localparam logic [2:0] OpMarkDirty  = 3'd1;
  localparam logic [2:0] OpSetBusy    = 3'd2;
  localparam logic [2:0] OpClearBusy  = 3'd3;
  localparam logic [2:0] OpFlush      = 3'd4;
  localparam logic [2:0] OpReleaseAll = 3'd5;
  localparam logic [2:0] OpReleaseOne = 3'd6;

  // error codes
  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrNoVictim = 2'd1;
  localparam logic [1:0] ErrDirtyHole = 2'd2;
  localparam logic [1:0] ErrBusy     = 2'd3;

  // command broadcast from the controller to every cell
  typedef struct packed {
    logic       alloc;       // write tag, set in_use, clear flags
    logic       set_dirty;
    logic       set_busy;
    logic       clr_busy;
    logic       clr_dirty;
    logic       clr_use;
  } cell_cmd_t;

endpackage : lbbc_pkg
`default_nettype wire

FILE: hdl/lru_block_buffer_cache.sv
`default_nettype none
// mark, busy and release one: the request passes the decode and emit states before the result beat is raised
// lookup: searches ranks from the front until a hit; a miss on a full
//   store searches, scans for a released entry and, failing that, walks back from the rear
// flush and release all: walk the ranks from the front, emitting a beat for each write-back or error
// one operation at a time; result held in an output register until taken
// reset: async active low, clears flags, count and control; tags undefined
module lru_block_buffer_cache #(
  parameter int unsigned ENTRIES    = lbbc_pkg::EntriesDef,
  parameter int unsigned BLOCK_BITS = lbbc_pkg::BlockBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic [3:0]  device_driver_i,
  input  wire logic [7:0]  device_minor_i,
  input  wire logic signed [BLOCK_BITS-1:0] block_number_i,
  input  wire logic        keep_order_i,
  input  wire logic [3:0]  entry_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       entry_o,
  output logic             hit_o,
  output logic             write_back_o,
  output logic [3:0]       wb_driver_o,
  output logic [7:0]       wb_minor_o,
  output logic signed [BLOCK_BITS-1:0] wb_block_o,
  output logic             fill_read_o,
  output logic             fill_clear_o,
  output logic [1:0]       error_o,
  output logic             last_o
);

  localparam int unsigned IdxBits  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntBits  = $clog2(ENTRIES + 1);
  localparam int unsigned ResBits  = $clog2(lbbc_pkg::MaxResults + 1);

  typedef enum logic [3:0] {
    StIdle, StDecode, StSearch, StFree, StVictim, StVictimBack, StAlloc,
    StWalk, StWalkEnd, StEmit, StDone
  } state_e;

  state_e state_q;

  // captured request
  logic [2:0]            op_q;
  logic [3:0]            drv_q;
  logic [7:0]            mnr_q;
  logic [BLOCK_BITS-1:0] blk_q;
  logic                  keep_q;
  logic [3:0]            idx_q;
  logic [CntBits-1:0]    taken_q;
  logic [CntBits-1:0]    k_q;      // rank being visited
  logic [IdxBits-1:0]    vict_q;
  logic [ResBits-1:0]    nres_q;
  logic                  after_q;  // walk beat parked until it is known whether it is last

  // cell row
  logic [ENTRIES-1:0]                 c_use, c_busy, c_dirty, c_sel, c_taken;
  logic [ENTRIES-1:0][3:0]            c_drv;
  logic [ENTRIES-1:0][7:0]            c_mnr;
  logic [ENTRIES-1:0][BLOCK_BITS-1:0] c_blk;
  logic [ENTRIES-1:0][IdxBits-1:0]    c_rank;
  lbbc_pkg::cell_cmd_t                cmd;
  logic                               sel_v;
  logic [IdxBits-1:0]                 sel_idx;
  logic                               rank_upd, rank_mode, shift_all;
  logic [IdxBits-1:0]                 ref_rank, new_rank;

  // entry currently at rank k_q
  logic               at_ok;
  logic [IdxBits-1:0] at_idx;
  always_comb begin
    at_ok  = 1'b0;
    at_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (c_taken[i] && CntBits'(c_rank[i]) == k_q && !at_ok) begin
        at_ok  = 1'b1;
        at_idx = IdxBits'(i);
      end
    end
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    assign c_taken[g] = CntBits'(g) < taken_q;
    assign c_sel[g]   = sel_v && (sel_idx == IdxBits'(g));
    lbbc_cell #(.RankBits(IdxBits), .BlockBits(BLOCK_BITS)) u_cell (
      .clk_i, .rst_ni,
      .sel_i(c_sel[g]), .cmd_i(cmd),
      .rank_upd_i(rank_upd), .rank_mode_i(rank_mode),
      .ref_rank_i(ref_rank), .new_rank_i(new_rank), .shift_all_i(shift_all),
      .taken_i(c_taken[g]),
      .drv_i(drv_q), .mnr_i(mnr_q), .blk_i(blk_q),
      .in_use_o(c_use[g]), .busy_o(c_busy[g]), .dirty_o(c_dirty[g]),
      .drv_o(c_drv[g]), .mnr_o(c_mnr[g]), .blk_o(c_blk[g]), .rank_o(c_rank[g])
    );
  end

  logic hole;
  assign hole = &blk_q;
  // taken entries always lie below ENTRIES
  logic idx_ok;
  assign idx_ok = (32'(idx_q) < 32'(taken_q));
  logic [IdxBits-1:0] idx_e;
  assign idx_e = IdxBits'(idx_q);
  logic [IdxBits-1:0] at_e;
  assign at_e = at_idx;

  // pending result register
  logic [3:0]            r_entry;
  logic                  r_hit, r_wb, r_fr, r_fc, r_last;
  logic [3:0]            r_drv;
  logic [7:0]            r_mnr;
  logic [BLOCK_BITS-1:0] r_blk;
  logic [1:0]            r_err;

  // combinational command to the cells
  always_comb begin
    cmd       = '0;
    sel_v     = 1'b0;
    sel_idx   = '0;
    rank_upd  = 1'b0;
    rank_mode = 1'b0;
    shift_all = 1'b0;
    ref_rank  = '0;
    new_rank  = '0;
    case (state_q)
      StDecode: begin
        sel_v   = idx_ok;
        sel_idx = idx_e;
        case (op_q)
          lbbc_pkg::OpMarkDirty: cmd.set_dirty = 1'b1;
          lbbc_pkg::OpSetBusy:   cmd.set_busy  = 1'b1;
          lbbc_pkg::OpClearBusy: cmd.clr_busy  = 1'b1;
          lbbc_pkg::OpReleaseOne: begin
            if (!c_busy[idx_e] && !(c_dirty[idx_e] && &c_blk[idx_e])) begin
              cmd.clr_dirty = 1'b1;
              cmd.clr_use   = 1'b1;
            end
          end
          default: sel_v = 1'b0;
        endcase
      end
      StSearch: begin
        if (at_ok && c_use[at_e] && c_blk[at_e] == blk_q &&
            (hole || (c_mnr[at_e] == mnr_q && c_drv[at_e] == drv_q)) && !keep_q) begin
          sel_v    = 1'b1;
          sel_idx  = at_e;
          rank_upd = 1'b1;
          ref_rank = c_rank[at_e];
          new_rank = '0;
        end
      end
      StAlloc: begin
        sel_v   = 1'b1;
        sel_idx = vict_q;
        cmd.alloc = 1'b1;
        rank_upd  = 1'b1;
        if (taken_q < CntBits'(ENTRIES)) begin
          shift_all = !keep_q;
          rank_mode = 1'b0;
          ref_rank  = '0;
          new_rank  = keep_q ? taken_q[IdxBits-1:0] : '0;
        end else begin
          rank_mode = keep_q;
          ref_rank  = c_rank[vict_q];
          new_rank  = keep_q ? IdxBits'(ENTRIES - 1) : '0;
        end
      end
      StWalk: begin
        if (at_ok && !c_busy[at_e] && !(c_dirty[at_e] && &c_blk[at_e])) begin
          sel_v         = 1'b1;
          sel_idx       = at_e;
          cmd.clr_dirty = 1'b1;
          cmd.clr_use   = (op_q == lbbc_pkg::OpReleaseAll);
        end
      end
      // release clean idle entries skipped while a walk beat is parked
      StDone: begin
        if (!out_valid_o && k_q < taken_q && nres_q < ResBits'(lbbc_pkg::MaxResults) &&
            at_ok && !c_busy[at_e] && !c_dirty[at_e] &&
            op_q == lbbc_pkg::OpReleaseAll) begin
          sel_v       = 1'b1;
          sel_idx     = at_e;
          cmd.clr_use = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // controller: state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      taken_q     <= '0;
      out_valid_o <= 1'b0;
      k_q         <= '0;
      nres_q      <= '0;
      after_q     <= 1'b0;
      op_q        <= '0;
      drv_q       <= '0;
      mnr_q       <= '0;
      blk_q       <= '0;
      keep_q      <= 1'b0;
      idx_q       <= '0;
      vict_q      <= '0;
      {r_entry, r_hit, r_wb, r_drv, r_mnr, r_blk, r_fr, r_fc, r_err} <= '0;
      r_last      <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            op_q    <= opcode_i;
            drv_q   <= device_driver_i;
            mnr_q   <= device_minor_i;
            blk_q   <= block_number_i;
            keep_q  <= keep_order_i;
            idx_q   <= entry_index_i;
            k_q     <= '0;
            nres_q  <= '0;
            state_q <= StDecode;
          end
        end
        StDecode: begin
          {r_entry, r_hit, r_wb, r_drv, r_mnr, r_blk, r_fr, r_fc, r_err} <= '0;
          r_last  <= 1'b1;
          after_q <= 1'b0;
          state_q <= StEmit;
          case (op_q)
            lbbc_pkg::OpLookup: state_q <= StSearch;
            lbbc_pkg::OpMarkDirty, lbbc_pkg::OpSetBusy, lbbc_pkg::OpClearBusy:
              r_entry <= idx_q;
            lbbc_pkg::OpReleaseOne: begin
              r_entry <= idx_q;
              if (idx_ok) begin
                if (c_busy[idx_e]) r_err <= lbbc_pkg::ErrBusy;
                else if (c_dirty[idx_e] && &c_blk[idx_e]) r_err <= lbbc_pkg::ErrDirtyHole;
                else if (c_dirty[idx_e]) begin
                  r_wb  <= 1'b1;
                  r_drv <= c_drv[idx_e];
                  r_mnr <= c_mnr[idx_e];
                  r_blk <= c_blk[idx_e];
                end
              end
            end
            lbbc_pkg::OpFlush, lbbc_pkg::OpReleaseAll: state_q <= StWalk;
            default: ;
          endcase
        end
        // search ranks from the front, one per cycle
        StSearch: begin
          if (k_q >= taken_q) begin
            k_q <= '0;
            if (taken_q < CntBits'(ENTRIES)) begin
              vict_q  <= taken_q[IdxBits-1:0];
              state_q <= StAlloc;
            end else begin
              state_q <= StFree;
            end
          end else if (at_ok && c_use[at_e] && c_blk[at_e] == blk_q &&
                       (hole || (c_mnr[at_e] == mnr_q && c_drv[at_e] == drv_q))) begin
            r_entry <= 4'(at_e);
            r_hit   <= 1'b1;
            state_q <= StEmit;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        // released entry nearest the front
        StFree: begin
          if (k_q >= taken_q) begin
            k_q     <= taken_q - 1'b1;
            state_q <= StVictimBack;
          end else if (at_ok && !c_use[at_e] && !c_busy[at_e] && !c_dirty[at_e]) begin
            vict_q  <= at_e;
            state_q <= StVictim;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        // rearmost non-busy entry
        StVictimBack: begin
          if (at_ok && !c_busy[at_e]) begin
            vict_q  <= at_e;
            state_q <= StVictim;
          end else if (k_q == '0) begin
            r_err   <= lbbc_pkg::ErrNoVictim;
            state_q <= StEmit;
          end else begin
            k_q <= k_q - 1'b1;
          end
        end
        StVictim: begin
          if (c_dirty[vict_q] && &c_blk[vict_q]) begin
            r_entry <= 4'(vict_q);
            r_err   <= lbbc_pkg::ErrDirtyHole;
            state_q <= StEmit;
          end else begin
            if (c_dirty[vict_q]) begin
              r_wb  <= 1'b1;
              r_drv <= c_drv[vict_q];
              r_mnr <= c_mnr[vict_q];
              r_blk <= c_blk[vict_q];
            end
            state_q <= StAlloc;
          end
        end
        StAlloc: begin
          r_entry <= 4'(vict_q);
          r_fr    <= !hole;
          r_fc    <= hole;
          if (taken_q < CntBits'(ENTRIES)) taken_q <= taken_q + 1'b1;
          state_q <= StEmit;
        end
        // flush and release all: one rank per cycle while no beat is being emitted
        StWalk: begin
          {r_entry, r_hit, r_wb, r_drv, r_mnr, r_blk, r_fr, r_fc, r_err} <= '0;
          r_last <= 1'b0;
          if (k_q >= taken_q) begin
            state_q <= StWalkEnd;
          end else begin
            k_q <= k_q + 1'b1;
            if (!at_ok) begin
              // nothing at this rank
            end else if (c_busy[at_e]) begin
              if (op_q != lbbc_pkg::OpReleaseAll) begin
                r_entry <= 4'(at_e);
                r_err   <= lbbc_pkg::ErrBusy;
                r_last  <= 1'b1;
                after_q <= 1'b0;
                if (nres_q < ResBits'(lbbc_pkg::MaxResults)) state_q <= StEmit;
                else state_q <= StWalkEnd;
              end
            end else if (c_dirty[at_e] && &c_blk[at_e]) begin
              r_entry <= 4'(at_e);
              r_err   <= lbbc_pkg::ErrDirtyHole;
              r_last  <= 1'b1;
              after_q <= 1'b0;
              if (nres_q < ResBits'(lbbc_pkg::MaxResults)) state_q <= StEmit;
              else state_q <= StWalkEnd;
            end else if (c_dirty[at_e] && nres_q < ResBits'(lbbc_pkg::MaxResults)) begin
              r_entry <= 4'(at_e);
              r_wb    <= 1'b1;
              r_drv   <= c_drv[at_e];
              r_mnr   <= c_mnr[at_e];
              r_blk   <= c_blk[at_e];
              after_q <= 1'b1;
              state_q <= StEmit;
            end
          end
        end
        // close the walk: send an empty last beat if no beat was sent
        StWalkEnd: begin
          if (out_valid_o) begin
            if (out_ready_i) begin
              out_valid_o <= 1'b0;
              if (nres_q == '0 || r_last) state_q <= StIdle;
            end
          end else if (nres_q == '0) begin
            {r_entry, r_hit, r_wb, r_drv, r_mnr, r_blk, r_fr, r_fc, r_err} <= '0;
            r_last      <= 1'b1;
            out_valid_o <= 1'b1;
            nres_q      <= nres_q + 1'b1;
          end else begin
            state_q <= StIdle;
          end
        end
        // hold a beat; walk beats wait to learn whether they are last
        StEmit: begin
          if (after_q) begin
            after_q <= 1'b0;
            nres_q  <= nres_q + 1'b1;
            state_q <= StDone;
          end else begin
            out_valid_o <= 1'b1;
            nres_q      <= nres_q + 1'b1;
            state_q     <= StDone;
          end
        end
        StDone: begin
          if (!out_valid_o) begin
            // walk beat parked: find out if another follows
            if (k_q >= taken_q || nres_q >= ResBits'(lbbc_pkg::MaxResults)) begin
              r_last      <= 1'b1;
              out_valid_o <= 1'b1;
            end else if (at_ok && c_busy[at_e] && op_q == lbbc_pkg::OpReleaseAll) begin
              k_q <= k_q + 1'b1;
            end else if (at_ok && (c_busy[at_e] || c_dirty[at_e])) begin
              out_valid_o <= 1'b1;
            end else begin
              // clean entry: released by the cell command on release all, skipped on flush
              k_q <= k_q + 1'b1;
            end
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= r_last ? StIdle : StWalk;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // payload
  assign in_ready_o   = (state_q == StIdle);
  assign entry_o      = r_entry;
  assign hit_o        = r_hit;
  assign write_back_o = r_wb;
  assign wb_driver_o  = r_drv;
  assign wb_minor_o   = r_mnr;
  assign wb_block_o   = r_blk;
  assign fill_read_o  = r_fr;
  assign fill_clear_o = r_fc;
  assign error_o      = r_err;
  assign last_o       = r_last;

endmodule : lru_block_buffer_cache
`default_nettype wire

FILE: hdl/lbbc_cell.sv
`default_nettype none
// one cache entry: tag, flags and recency rank
module lbbc_cell #(
  parameter int unsigned RankBits  = 4,
  parameter int unsigned BlockBits = 25
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 sel_i,       // this cell is the target
  input  wire lbbc_pkg::cell_cmd_t  cmd_i,
  input  wire logic                 rank_upd_i,  // apply a rank move
  input  wire logic                 rank_mode_i, // 0 front, 1 back
  input  wire logic [RankBits-1:0]  ref_rank_i,  // old rank of the moved entry
  input  wire logic [RankBits-1:0]  new_rank_i,  // rank the moved entry takes
  input  wire logic                 shift_all_i, // every taken entry steps back
  input  wire logic                 taken_i,
  input  wire logic [3:0]           drv_i,
  input  wire logic [7:0]           mnr_i,
  input  wire logic [BlockBits-1:0] blk_i,
  output logic                      in_use_o,
  output logic                      busy_o,
  output logic                      dirty_o,
  output logic [3:0]                drv_o,
  output logic [7:0]                mnr_o,
  output logic [BlockBits-1:0]      blk_o,
  output logic [RankBits-1:0]       rank_o
);

  logic                 use_q, busy_q, dirty_q;
  logic [3:0]           drv_q;
  logic [7:0]           mnr_q;
  logic [BlockBits-1:0] blk_q;
  logic [RankBits-1:0]  rank_q, rank_d;

  // rank update
  always_comb begin
    rank_d = rank_q;
    if (rank_upd_i && taken_i) begin
      if (sel_i) begin
        rank_d = new_rank_i;
      end else if (shift_all_i) begin
        rank_d = rank_q + 1'b1;
      end else if (!rank_mode_i && rank_q < ref_rank_i) begin
        rank_d = rank_q + 1'b1;
      end else if (rank_mode_i && rank_q > ref_rank_i) begin
        rank_d = rank_q - 1'b1;
      end
    end else if (rank_upd_i && sel_i) begin
      rank_d = new_rank_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_q   <= 1'b0;
      busy_q  <= 1'b0;
      dirty_q <= 1'b0;
    end else if (sel_i) begin
      if (cmd_i.alloc) begin
        use_q <= 1'b1; busy_q <= 1'b0; dirty_q <= 1'b0;
      end
      if (cmd_i.set_dirty) dirty_q <= 1'b1;
      if (cmd_i.set_busy)  busy_q  <= 1'b1;
      if (cmd_i.clr_busy)  busy_q  <= 1'b0;
      if (cmd_i.clr_dirty) dirty_q <= 1'b0;
      if (cmd_i.clr_use)   use_q   <= 1'b0;
    end
  end

  // tags and rank carry no reset
  always_ff @(posedge clk_i) begin
    rank_q <= rank_d;
    if (sel_i && cmd_i.alloc) begin
      drv_q <= drv_i;
      mnr_q <= mnr_i;
      blk_q <= blk_i;
    end
  end

  assign in_use_o = use_q;
  assign busy_o   = busy_q;
  assign dirty_o  = dirty_q;
  assign drv_o    = drv_q;
  assign mnr_o    = mnr_q;
  assign blk_o    = blk_q;
  assign rank_o   = rank_q;

endmodule : lbbc_cell
`default_nettype wire
